/* hw/rtl/owbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

  // command codes carried by an input item
  localparam logic [1:0] CMD_IDLE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_WAIT     = 3'd4;

  // register reset values
  localparam logic [9:0] RESET_LOW_DEF     = 10'd960;
  localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd60;
  localparam logic [9:0] RESET_TAIL_DEF    = 10'd480;
  localparam logic [7:0] WRITE_SLOT_DEF    = 8'd80;
  localparam logic [7:0] READ_WAIT_DEF     = 8'd70;

  // fixed length of short lows, short releases and recovery phases
  localparam logic [15:0] SHORT_US = 16'd2;

  localparam int unsigned TIMER_BITS_DEF = 10;
  localparam int unsigned LEN_W = 16;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] write_data;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_presence;
  } out_item_t;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [7:0] presence_wait_us;
    logic [9:0] reset_tail_us;
    logic [7:0] write_slot_us;
    logic [7:0] read_wait_us;
  } cfg_t;

  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_RST_LOW  = 11'b000_0000_0010,
    PH_RST_WAIT = 11'b000_0000_0100,
    PH_RST_TAIL = 11'b000_0000_1000,
    PH_WR_LOW   = 11'b000_0001_0000,
    PH_WR_DATA  = 11'b000_0010_0000,
    PH_WR_REC   = 11'b000_0100_0000,
    PH_RD_LOW   = 11'b000_1000_0000,
    PH_RD_REL   = 11'b001_0000_0000,
    PH_RD_WAIT  = 11'b010_0000_0000,
    PH_RD_REC   = 11'b100_0000_0000
  } phase_t;

endpackage

`default_nettype wire

/* hw/rtl/owbm_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module owbm_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [owbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [owbm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output owbm_pkg::cfg_t                          cfg
);

  owbm_pkg::cfg_t regs;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg = regs;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.reset_low_us     <= owbm_pkg::RESET_LOW_DEF;
      regs.presence_wait_us <= owbm_pkg::PRESENCE_WAIT_DEF;
      regs.reset_tail_us    <= owbm_pkg::RESET_TAIL_DEF;
      regs.write_slot_us    <= owbm_pkg::WRITE_SLOT_DEF;
      regs.read_wait_us     <= owbm_pkg::READ_WAIT_DEF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        owbm_pkg::CFG_RESET_LOW:     regs.reset_low_us     <= cfg_data[9:0];
        owbm_pkg::CFG_PRESENCE_WAIT: regs.presence_wait_us <= cfg_data[7:0];
        owbm_pkg::CFG_RESET_TAIL:    regs.reset_tail_us    <= cfg_data[9:0];
        owbm_pkg::CFG_WRITE_SLOT:    regs.write_slot_us    <= cfg_data[7:0];
        owbm_pkg::CFG_READ_WAIT:     regs.read_wait_us     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/owbm_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module owbm_core #(
  parameter int unsigned TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire owbm_pkg::in_item_t   item,
  input  wire owbm_pkg::cfg_t       cfg,
  output owbm_pkg::out_item_t       result
);

  owbm_pkg::phase_t       phase, phase_next, cur_phase, start_phase;
  logic [TIMER_BITS-1:0]  tick_timer, timer_next, cur_timer;
  logic [2:0]             bit_index, bit_next, cur_bit;
  logic [7:0]             shift_reg, shift_next, cur_shift;
  logic [7:0]             read_byte_reg, read_byte_next;
  logic                   absent_flag, absent_next;
  logic                   start, busy, drive, done;

  // phase length, masked to the timer width
  function automatic logic [TIMER_BITS-1:0] phase_len(owbm_pkg::phase_t p,
                                                      owbm_pkg::cfg_t c);
    logic [owbm_pkg::LEN_W-1:0] len;
    begin
      case (p)
        owbm_pkg::PH_RST_LOW:  len = {6'd0, c.reset_low_us};
        owbm_pkg::PH_RST_WAIT: len = {8'd0, c.presence_wait_us};
        owbm_pkg::PH_RST_TAIL: len = {6'd0, c.reset_tail_us};
        owbm_pkg::PH_WR_DATA:  len = {8'd0, c.write_slot_us};
        owbm_pkg::PH_RD_WAIT:  len = {8'd0, c.read_wait_us};
        default:               len = owbm_pkg::SHORT_US;
      endcase
      phase_len = len[TIMER_BITS-1:0];
    end
  endfunction

  // command start on an idle tick takes effect on the same tick
  always_comb begin
    start = (phase == owbm_pkg::PH_IDLE) && (item.cmd != owbm_pkg::CMD_IDLE);
    case (item.cmd)
      owbm_pkg::CMD_RESET: start_phase = owbm_pkg::PH_RST_LOW;
      owbm_pkg::CMD_WRITE: start_phase = owbm_pkg::PH_WR_LOW;
      default:             start_phase = owbm_pkg::PH_RD_LOW;
    endcase
    cur_phase = start ? start_phase : phase;
    cur_timer = start ? phase_len(start_phase, cfg) : tick_timer;
    cur_bit   = start ? 3'd0 : bit_index;
    if (start) begin
      cur_shift = (item.cmd == owbm_pkg::CMD_WRITE) ? item.write_data : 8'd0;
    end else begin
      cur_shift = shift_reg;
    end
  end

  // line drive for this tick
  always_comb begin
    busy = (cur_phase != owbm_pkg::PH_IDLE);
    case (cur_phase)
      owbm_pkg::PH_RST_LOW, owbm_pkg::PH_WR_LOW, owbm_pkg::PH_RD_LOW: drive = 1'b1;
      owbm_pkg::PH_WR_DATA: drive = ~cur_shift[0];
      default:              drive = 1'b0;
    endcase
  end

  // countdown and phase sequencing
  always_comb begin
    phase_next     = cur_phase;
    timer_next     = cur_timer;
    bit_next       = cur_bit;
    shift_next     = cur_shift;
    read_byte_next = read_byte_reg;
    absent_next    = absent_flag;
    done           = 1'b0;
    if (busy) begin
      if (cur_timer > TIMER_BITS'(1)) begin
        timer_next = cur_timer - TIMER_BITS'(1);
      end else begin
        case (cur_phase)
          owbm_pkg::PH_RST_LOW: begin
            phase_next = owbm_pkg::PH_RST_WAIT;
            timer_next = phase_len(owbm_pkg::PH_RST_WAIT, cfg);
          end
          owbm_pkg::PH_RST_WAIT: begin
            absent_next = item.line_level;
            phase_next  = owbm_pkg::PH_RST_TAIL;
            timer_next  = phase_len(owbm_pkg::PH_RST_TAIL, cfg);
          end
          owbm_pkg::PH_RST_TAIL: begin
            done       = 1'b1;
            phase_next = owbm_pkg::PH_IDLE;
            timer_next = '0;
            bit_next   = 3'd0;
          end
          owbm_pkg::PH_WR_LOW: begin
            phase_next = owbm_pkg::PH_WR_DATA;
            timer_next = phase_len(owbm_pkg::PH_WR_DATA, cfg);
          end
          owbm_pkg::PH_WR_DATA: begin
            phase_next = owbm_pkg::PH_WR_REC;
            timer_next = phase_len(owbm_pkg::PH_WR_REC, cfg);
          end
          owbm_pkg::PH_WR_REC: begin
            shift_next = {1'b0, cur_shift[7:1]};
            if (cur_bit == 3'd7) begin
              done       = 1'b1;
              phase_next = owbm_pkg::PH_IDLE;
              timer_next = '0;
              bit_next   = 3'd0;
            end else begin
              bit_next   = cur_bit + 3'd1;
              phase_next = owbm_pkg::PH_WR_LOW;
              timer_next = phase_len(owbm_pkg::PH_WR_LOW, cfg);
            end
          end
          owbm_pkg::PH_RD_LOW: begin
            phase_next = owbm_pkg::PH_RD_REL;
            timer_next = phase_len(owbm_pkg::PH_RD_REL, cfg);
          end
          owbm_pkg::PH_RD_REL: begin
            shift_next = {item.line_level, cur_shift[7:1]};
            phase_next = owbm_pkg::PH_RD_WAIT;
            timer_next = phase_len(owbm_pkg::PH_RD_WAIT, cfg);
          end
          owbm_pkg::PH_RD_WAIT: begin
            phase_next = owbm_pkg::PH_RD_REC;
            timer_next = phase_len(owbm_pkg::PH_RD_REC, cfg);
          end
          owbm_pkg::PH_RD_REC: begin
            if (cur_bit == 3'd7) begin
              read_byte_next = cur_shift;
              done           = 1'b1;
              phase_next     = owbm_pkg::PH_IDLE;
              timer_next     = '0;
              bit_next       = 3'd0;
            end else begin
              bit_next   = cur_bit + 3'd1;
              phase_next = owbm_pkg::PH_RD_LOW;
              timer_next = phase_len(owbm_pkg::PH_RD_LOW, cfg);
            end
          end
          default: begin
            phase_next = owbm_pkg::PH_IDLE;
            timer_next = '0;
            bit_next   = 3'd0;
          end
        endcase
      end
    end
  end

  // result for this tick
  always_comb begin
    result.drive_low   = drive;
    result.busy_res    = busy;
    result.done_res    = done;
    result.read_data   = read_byte_next;
    result.no_presence = absent_next;
  end

  // state advances once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= owbm_pkg::PH_IDLE;
      tick_timer    <= '0;
      bit_index     <= 3'd0;
      shift_reg     <= 8'd0;
      read_byte_reg <= 8'd0;
      absent_flag   <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      tick_timer    <= timer_next;
      bit_index     <= bit_next;
      shift_reg     <= shift_next;
      read_byte_reg <= read_byte_next;
      absent_flag   <= absent_next;
    end
  end

  // checks
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == owbm_pkg::PH_IDLE |-> tick_timer == '0 && bit_index == 3'd0)
    else $error("idle phase with live timer or bit index");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    step && done |=> phase == owbm_pkg::PH_IDLE)
    else $error("operation did not return to idle after done");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !drive && !done)
    else $error("line driven or done raised while not busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(tick_timer) && $stable(shift_reg))
    else $error("state changed without an item");

endmodule

`default_nettype wire

/* hw/rtl/one_wire_bus_master.sv */
`timescale 1ns / 1ps
`default_nettype none

// Single-wire bus master, one input item per microsecond tick of bus time.
// Input channel (in_valid / in_stall / in_item): command, byte to write and
// the sampled line level for one tick. Output channel (out_valid / out_stall /
// out_item): line drive, busy, done, last byte read and no-presence flag, one
// result item per input item, in order.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
// the five timing registers; cfg_ready is always high, unknown indexes are
// dropped. Write them only while no item is in flight.
// An accepted item passes through the input register, then the result
// register, before its result is on out_item.
// Throughput: one item per cycle while out_stall does not hold the result;
// the phase sequencer updates its timer and bit state once per item.
// Reset (rst, synchronous) empties both registers, returns the sequencer to
// idle with cleared read byte and presence flag, and loads the default
// timings. A stalled result holds; one more item may still be taken into the
// input register, after which in_stall rises until the result is taken.

module one_wire_bus_master #(
  parameter int unsigned TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire owbm_pkg::in_item_t               in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output owbm_pkg::out_item_t                   out_item,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [owbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [owbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  owbm_pkg::cfg_t      cfg;
  owbm_pkg::in_item_t  in_q;
  owbm_pkg::out_item_t core_result;
  logic                in_valid_q;
  logic                advance, step;

  owbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // result register can take a new item
  assign advance  = !out_valid || !out_stall;
  assign step     = in_valid_q && advance;
  assign in_stall = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_item;
    end
  end

  owbm_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_q),
    .cfg    (cfg),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= core_result;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_one_wire_bus_master.sv */
`timescale 1ns / 1ps

module tb_one_wire_bus_master;

  localparam int TIMER_W = owbm_pkg::TIMER_BITS_DEF;
  localparam int SETTLE_CYCLES = 4;

  // one row of the directed plan: either a register write or a tick item
  typedef struct {
    bit                              is_cfg;
    logic [owbm_pkg::CFG_IDX_W-1:0]  idx;
    logic [owbm_pkg::CFG_DATA_W-1:0] data;
    owbm_pkg::in_item_t              item;
    bit                              typed;
    owbm_pkg::out_item_t             res;
  } tick_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  owbm_pkg::in_item_t in_item = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [owbm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall;
  logic out_valid;
  owbm_pkg::out_item_t out_item;
  logic cfg_ready;

  // bus master model state
  owbm_pkg::cfg_t     timing;
  owbm_pkg::phase_t   bus_phase;
  logic [TIMER_W-1:0] slot_timer;
  logic [2:0]         bit_pos;
  logic [7:0]         shifter;
  logic [7:0]         last_read;
  logic               absent;

  owbm_pkg::out_item_t tick_answers[$];
  tick_row_t plan[$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int fails = 0;
  int n_ticks = 0;
  int n_checked = 0;
  int n_cfg_writes = 0;
  int n_resets = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_done = 0;

  one_wire_bus_master u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // phase length from the current timing registers
  function automatic logic [owbm_pkg::LEN_W-1:0] phase_ticks(owbm_pkg::phase_t p);
    case (p)
      owbm_pkg::PH_RST_LOW:  phase_ticks = owbm_pkg::LEN_W'(timing.reset_low_us);
      owbm_pkg::PH_RST_WAIT: phase_ticks = owbm_pkg::LEN_W'(timing.presence_wait_us);
      owbm_pkg::PH_RST_TAIL: phase_ticks = owbm_pkg::LEN_W'(timing.reset_tail_us);
      owbm_pkg::PH_WR_DATA:  phase_ticks = owbm_pkg::LEN_W'(timing.write_slot_us);
      owbm_pkg::PH_RD_WAIT:  phase_ticks = owbm_pkg::LEN_W'(timing.read_wait_us);
      default:               phase_ticks = owbm_pkg::SHORT_US;
    endcase
  endfunction

  task automatic enter_phase(input owbm_pkg::phase_t p);
    bus_phase = p;
    slot_timer = TIMER_W'(phase_ticks(p));
  endtask

  task automatic end_op();
    bus_phase = owbm_pkg::PH_IDLE;
    slot_timer = '0;
    bit_pos = '0;
  endtask

  // one microsecond tick of the bus master
  task automatic bus_tick(input owbm_pkg::in_item_t it, output owbm_pkg::out_item_t r);
    logic drive;
    logic busy;
    logic done;
    drive = 1'b0;
    done = 1'b0;
    if (bus_phase == owbm_pkg::PH_IDLE && it.cmd != owbm_pkg::CMD_IDLE) begin
      bit_pos = '0;
      shifter = (it.cmd == owbm_pkg::CMD_WRITE) ? it.write_data : 8'h00;
      case (it.cmd)
        owbm_pkg::CMD_RESET: begin
          enter_phase(owbm_pkg::PH_RST_LOW);
          n_resets++;
        end
        owbm_pkg::CMD_WRITE: begin
          enter_phase(owbm_pkg::PH_WR_LOW);
          n_writes++;
        end
        default: begin
          enter_phase(owbm_pkg::PH_RD_LOW);
          n_reads++;
        end
      endcase
    end
    busy = (bus_phase != owbm_pkg::PH_IDLE);
    if (bus_phase == owbm_pkg::PH_RST_LOW || bus_phase == owbm_pkg::PH_WR_LOW ||
        bus_phase == owbm_pkg::PH_RD_LOW)
      drive = 1'b1;
    else if (bus_phase == owbm_pkg::PH_WR_DATA)
      drive = ~shifter[0];
    if (busy) begin
      if (slot_timer > 1) begin
        slot_timer = slot_timer - 1'b1;
      end else begin
        case (bus_phase)
          owbm_pkg::PH_RST_LOW: enter_phase(owbm_pkg::PH_RST_WAIT);
          owbm_pkg::PH_RST_WAIT: begin
            absent = it.line_level;
            enter_phase(owbm_pkg::PH_RST_TAIL);
          end
          owbm_pkg::PH_RST_TAIL: begin
            done = 1'b1;
            end_op();
          end
          owbm_pkg::PH_WR_LOW: enter_phase(owbm_pkg::PH_WR_DATA);
          owbm_pkg::PH_WR_DATA: enter_phase(owbm_pkg::PH_WR_REC);
          owbm_pkg::PH_WR_REC: begin
            shifter = shifter >> 1;
            if (bit_pos == 3'd7) begin
              done = 1'b1;
              end_op();
            end else begin
              bit_pos = bit_pos + 1'b1;
              enter_phase(owbm_pkg::PH_WR_LOW);
            end
          end
          owbm_pkg::PH_RD_LOW: enter_phase(owbm_pkg::PH_RD_REL);
          owbm_pkg::PH_RD_REL: begin
            shifter = {it.line_level, shifter[7:1]};
            enter_phase(owbm_pkg::PH_RD_WAIT);
          end
          owbm_pkg::PH_RD_WAIT: enter_phase(owbm_pkg::PH_RD_REC);
          owbm_pkg::PH_RD_REC: begin
            if (bit_pos == 3'd7) begin
              last_read = shifter;
              done = 1'b1;
              end_op();
            end else begin
              bit_pos = bit_pos + 1'b1;
              enter_phase(owbm_pkg::PH_RD_LOW);
            end
          end
          default: end_op();
        endcase
      end
    end
    if (done)
      n_done++;
    r.drive_low = drive;
    r.busy_res = busy;
    r.done_res = done;
    r.read_data = last_read;
    r.no_presence = absent;
  endtask

  // result side: random stall, compare each taken item with the oldest answer
  always @(posedge clk) begin
    owbm_pkg::out_item_t want;
    if (out_valid && !out_stall) begin
      if (tick_answers.size() == 0) begin
        $error("result item with nothing expected: %h", out_item);
        fails++;
      end else begin
        want = tick_answers.pop_front();
        n_checked++;
        if (out_item.drive_low !== want.drive_low) begin
          $error("drive_low: expected %0d, got %0d", want.drive_low, out_item.drive_low);
          fails++;
        end
        if (out_item.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_item.busy_res);
          fails++;
        end
        if (out_item.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_item.done_res);
          fails++;
        end
        if (out_item.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_item.read_data);
          fails++;
        end
        if (out_item.no_presence !== want.no_presence) begin
          $error("no_presence: expected %0d, got %0d", want.no_presence,
                 out_item.no_presence);
          fails++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // offer one tick item, with random gaps, and record its answer on acceptance
  task automatic send_tick(input owbm_pkg::in_item_t it, input bit typed,
                           input owbm_pkg::out_item_t res);
    owbm_pkg::out_item_t r;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    bus_tick(it, r);
    tick_answers.push_back(typed ? res : r);
    n_ticks++;
  endtask

  // hold the sender until every answer has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tick_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [owbm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [owbm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      owbm_pkg::CFG_RESET_LOW:     timing.reset_low_us = data;
      owbm_pkg::CFG_PRESENCE_WAIT: timing.presence_wait_us = data[7:0];
      owbm_pkg::CFG_RESET_TAIL:    timing.reset_tail_us = data;
      owbm_pkg::CFG_WRITE_SLOT:    timing.write_slot_us = data[7:0];
      owbm_pkg::CFG_READ_WAIT:     timing.read_wait_us = data[7:0];
      default: ;
    endcase
    n_cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_timings(input logic [9:0] rst_low, input logic [9:0] pres_wait,
                               input logic [9:0] rst_tail, input logic [9:0] wr_slot,
                               input logic [9:0] rd_wait);
    drain_results();
    write_reg(owbm_pkg::CFG_RESET_LOW, rst_low);
    write_reg(owbm_pkg::CFG_PRESENCE_WAIT, pres_wait);
    write_reg(owbm_pkg::CFG_RESET_TAIL, rst_tail);
    write_reg(owbm_pkg::CFG_WRITE_SLOT, wr_slot);
    write_reg(owbm_pkg::CFG_READ_WAIT, rd_wait);
  endtask

  // mostly tiny lengths so that many operations finish
  function automatic logic [9:0] short_len();
    if ($urandom_range(0, 3) == 0)
      short_len = 10'($urandom_range(0, 12));
    else
      short_len = 10'($urandom_range(0, 4));
  endfunction

  function automatic owbm_pkg::in_item_t random_tick();
    owbm_pkg::in_item_t t;
    if ($urandom_range(0, 99) < 55) begin
      t.cmd = owbm_pkg::CMD_IDLE;
    end else begin
      case ($urandom_range(0, 2))
        0: t.cmd = owbm_pkg::CMD_RESET;
        1: t.cmd = owbm_pkg::CMD_WRITE;
        default: t.cmd = owbm_pkg::CMD_READ;
      endcase
    end
    t.write_data = 8'($urandom);
    t.line_level = 1'($urandom_range(0, 1));
    random_tick = t;
  endfunction

  task automatic random_ticks(input int count);
    int hold_at;
    hold_at = $urandom_range(count / 4, (3 * count) / 4);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at)
        drain_results();
      send_tick(random_tick(), 1'b0, '0);
    end
  endtask

  function automatic owbm_pkg::in_item_t tick_of(input logic [1:0] cmd,
                                                 input logic [7:0] wd, input logic lv);
    owbm_pkg::in_item_t t;
    t.cmd = cmd;
    t.write_data = wd;
    t.line_level = lv;
    tick_of = t;
  endfunction

  function automatic tick_row_t item_row(input logic [1:0] cmd, input logic [7:0] wd,
                                         input logic lv);
    item_row = '{is_cfg: 1'b0, idx: '0, data: '0, item: tick_of(cmd, wd, lv),
                 typed: 1'b0, res: '0};
  endfunction

  function automatic tick_row_t typed_row(input logic [1:0] cmd, input logic [7:0] wd,
                                          input logic lv, input owbm_pkg::out_item_t res);
    typed_row = '{is_cfg: 1'b0, idx: '0, data: '0, item: tick_of(cmd, wd, lv),
                  typed: 1'b1, res: res};
  endfunction

  function automatic tick_row_t cfg_row(input logic [owbm_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [owbm_pkg::CFG_DATA_W-1:0] data);
    cfg_row = '{is_cfg: 1'b1, idx: idx, data: data, item: '0, typed: 1'b0, res: '0};
  endfunction

  initial begin
    timing.reset_low_us = owbm_pkg::RESET_LOW_DEF;
    timing.presence_wait_us = owbm_pkg::PRESENCE_WAIT_DEF;
    timing.reset_tail_us = owbm_pkg::RESET_TAIL_DEF;
    timing.write_slot_us = owbm_pkg::WRITE_SLOT_DEF;
    timing.read_wait_us = owbm_pkg::READ_WAIT_DEF;
    bus_phase = owbm_pkg::PH_IDLE;
    slot_timer = '0;
    bit_pos = '0;
    shifter = '0;
    last_read = '0;
    absent = 1'b0;

    // directed plan: idle after reset, zero lengths, ignored commands and indexes
    plan.push_back(typed_row(owbm_pkg::CMD_IDLE, 8'hFF, 1'b1, '0));
    plan.push_back(typed_row(owbm_pkg::CMD_IDLE, 8'h00, 1'b0, '0));
    plan.push_back(cfg_row(owbm_pkg::CFG_RESET_LOW, '0));
    plan.push_back(cfg_row(owbm_pkg::CFG_PRESENCE_WAIT, '0));
    plan.push_back(cfg_row(owbm_pkg::CFG_RESET_TAIL, '0));
    plan.push_back(cfg_row(owbm_pkg::CFG_WRITE_SLOT, '0));
    plan.push_back(cfg_row(owbm_pkg::CFG_READ_WAIT, '0));
    plan.push_back(cfg_row(owbm_pkg::CFG_READ_WAIT + 3'd1, 10'h3FF));
    plan.push_back(cfg_row(3'd7, 10'h2AA));
    plan.push_back(typed_row(owbm_pkg::CMD_RESET, 8'h00, 1'b1,
                             '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0}));
    plan.push_back(item_row(owbm_pkg::CMD_IDLE, 8'h55, 1'b1));
    plan.push_back(item_row(owbm_pkg::CMD_WRITE, 8'hAA, 1'b1));
    plan.push_back(item_row(owbm_pkg::CMD_RESET, 8'h00, 1'b0));
    plan.push_back(item_row(owbm_pkg::CMD_IDLE, 8'h00, 1'b0));
    plan.push_back(item_row(owbm_pkg::CMD_IDLE, 8'h00, 1'b0));
    plan.push_back(item_row(owbm_pkg::CMD_READ, 8'h00, 1'b1));
    plan.push_back(item_row(owbm_pkg::CMD_WRITE, 8'h00, 1'b0));
    plan.push_back(item_row(owbm_pkg::CMD_IDLE, 8'hFF, 1'b1));
    plan.push_back(item_row(owbm_pkg::CMD_IDLE, 8'h00, 1'b0));
    // change a length while a read is still running
    plan.push_back(cfg_row(owbm_pkg::CFG_READ_WAIT, 10'd3));
    plan.push_back(item_row(owbm_pkg::CMD_IDLE, 8'h00, 1'b1));
    plan.push_back(item_row(owbm_pkg::CMD_IDLE, 8'h00, 1'b1));
    plan.push_back(item_row(owbm_pkg::CMD_IDLE, 8'h00, 1'b0));
    plan.push_back(item_row(owbm_pkg::CMD_IDLE, 8'h00, 1'b1));
    plan.push_back(item_row(owbm_pkg::CMD_WRITE, 8'h3C, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 32;
    recv_stall_pct = 56;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].item, plan[i].typed, plan[i].res);
      end
    end

    // random phases with small lengths under three idling patterns
    write_timings(short_len(), short_len(), short_len(), short_len(), short_len());
    random_ticks(360);

    send_gap_pct = 56;
    recv_stall_pct = 32;
    write_timings(short_len(), short_len(), short_len(), short_len(), short_len());
    random_ticks(360);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_timings(short_len(), short_len(), short_len(), short_len(), short_len());
    random_ticks(360);

    // largest lengths, then back to zero while an operation is still running
    write_timings(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
    random_ticks(250);
    write_timings('0, '0, '0, '0, '0);
    random_ticks(120);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tick_answers.size() != 0) begin
      $error("%0d expected result items never arrived", tick_answers.size());
      fails++;
    end

    $display("covered %0d ticks, %0d compared: %0d resets, %0d writes, %0d reads, %0d done",
             n_ticks, n_checked, n_resets, n_writes, n_reads, n_done);
    $display("%0d timing register writes across zero, small and full-scale lengths",
             n_cfg_writes);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
